// ----- rtl/core/olt_pkg.sv -----
`timescale 1ns / 1ps

package olt_pkg;

	// Default sizing
	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned ITEM_W  = 32;
	localparam int unsigned REM_W   = 32;
	localparam int unsigned COUNT_W = 5;

	// Command codes (code 7 is unused)
	typedef enum logic [CMD_W-1:0] {
		CMD_INS_ORD   = 3'd0,
		CMD_INS_FRONT = 3'd1,
		CMD_INS_REAR  = 3'd2,
		CMD_SEARCH    = 3'd3,
		CMD_REM_FRONT = 3'd4,
		CMD_REM_REAR  = 3'd5,
		CMD_REM_VAL   = 3'd6
	} cmd_t;

	// Which cell condition marks the position a command acts on
	typedef enum logic [2:0] {
		MK_NONE,
		MK_ORD,     // first entry >= key, or first free slot
		MK_FRONT,   // every cell, so the first one wins
		MK_FREE,    // first free slot
		MK_VALID,   // first valid entry
		MK_LAST,    // last valid entry
		MK_EQ       // first entry equal to key
	} mark_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic  ins;
		logic  rem;
		mark_t mark;
	} ctl_t;

endpackage

// ----- rtl/core/olt_cell.sv -----
`timescale 1ns / 1ps

module olt_cell #(
	parameter int unsigned DATA_WIDTH = olt_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  olt_pkg::ctl_t         ctl,
	input  logic [DATA_WIDTH-1:0] key,
	input  logic [DATA_WIDTH-1:0] left_val,
	input  logic                  left_vld,
	input  logic [DATA_WIDTH-1:0] right_val,
	input  logic                  right_vld,
	input  logic                  hit_in,
	output logic                  hit_out,
	input  logic [DATA_WIDTH-1:0] acc_in,
	output logic [DATA_WIDTH-1:0] acc_out,
	output logic [DATA_WIDTH-1:0] val,
	output logic                  vld
);
	import olt_pkg::*;

	logic [DATA_WIDTH-1:0] val_q;
	logic                  vld_q;
	logic                  ge;
	logic                  eq;
	logic                  mark;
	logic                  here;

	// Local compare and mark selection
	always_comb begin
		ge = vld_q && (val_q >= key);
		eq = vld_q && (val_q == key);
		case (ctl.mark)
			MK_ORD:   mark = ge || !vld_q;
			MK_FRONT: mark = 1'b1;
			MK_FREE:  mark = !vld_q;
			MK_VALID: mark = vld_q;
			MK_LAST:  mark = vld_q && !right_vld;
			MK_EQ:    mark = eq;
			default:  mark = 1'b0;
		endcase
	end

	// First mark along the chain owns the command
	assign here    = mark && !hit_in;
	assign hit_out = hit_in || mark;
	assign acc_out = acc_in | (here ? val_q : '0);

	// Valid bit: insert shifts toward the rear, remove pulls from the rear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.ins) begin
			if (hit_in) vld_q <= left_vld;
			else if (here) vld_q <= 1'b1;
		end else if (ctl.rem) begin
			if (hit_in || here) vld_q <= right_vld;
		end
	end

	// Stored value
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (hit_in) val_q <= left_val;
			else if (here) val_q <= key;
		end else if (ctl.rem) begin
			if (hit_in || here) val_q <= right_val;
		end
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule

// ----- rtl/core/ordered_list_table_unit.sv -----
`timescale 1ns / 1ps

// Channel | Dir | tdata (low bit first)                          | tuser
// s_*     | in  | item_value[31:0]                               | cmd[2:0]
// m_*     | out | ok[0], removed_value[32:1], entry_count[37:33] | -
//
// One request per cycle while s_tready is high: every command is settled
// combinationally by the row of DEPTH cells, with the first-match flag and removed
// value rippling from cell to cell. The result is registered and shown in the cycle after acceptance.
// Reset clears every valid bit and the fill count at once; no clearing pass.
// s_tready stays high while the output register is empty or being drained.

module ordered_list_table_unit #(
	parameter int unsigned DEPTH      = olt_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = olt_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // item_value[31:0]
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // ok, removed_value, entry_count, zero pad
);
	import olt_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic                  accept;
	logic [63:0]           item_ext;
	logic [DATA_WIDTH-1:0] key;
	cmd_t                  cmd;
	ctl_t                  ctl;
	logic                  full;
	logic                  is_ins;
	logic                  is_rem;
	logic                  ok_c;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         fill_nxt;
	logic [63:0]           cnt_ext;
	logic [63:0]           rem_ext;

	logic [DEPTH:0]                 hit;
	logic [DEPTH:0][DATA_WIDTH-1:0] acc;
	logic [DEPTH-1:0][DATA_WIDTH-1:0] val;
	logic [DEPTH-1:0]               vld;

	logic                  out_vld_q;
	logic                  ok_q;
	logic [REM_W-1:0]      rem_q;
	logic [COUNT_W-1:0]    cnt_q;

	assign s_tready = !out_vld_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign item_ext = 64'(s_tdata);
	assign key      = item_ext[DATA_WIDTH-1:0];
	assign cmd      = cmd_t'(s_tuser);
	assign full     = (fill_q == CW'(DEPTH));

	// Command decode
	always_comb begin
		is_ins   = 1'b0;
		is_rem   = 1'b0;
		ctl.mark = MK_NONE;
		case (cmd)
			CMD_INS_ORD:   begin is_ins = 1'b1; ctl.mark = MK_ORD;   end
			CMD_INS_FRONT: begin is_ins = 1'b1; ctl.mark = MK_FRONT; end
			CMD_INS_REAR:  begin is_ins = 1'b1; ctl.mark = MK_FREE;  end
			CMD_SEARCH:    begin ctl.mark = MK_EQ; end
			CMD_REM_FRONT: begin is_rem = 1'b1; ctl.mark = MK_VALID; end
			CMD_REM_REAR:  begin is_rem = 1'b1; ctl.mark = MK_LAST;  end
			CMD_REM_VAL:   begin is_rem = 1'b1; ctl.mark = MK_EQ;    end
			default:       begin ctl.mark = MK_NONE; end
		endcase
		ctl.ins = accept && is_ins && !full;
		ctl.rem = accept && is_rem;
	end

	// Row of cells
	assign hit[0] = 1'b0;
	assign acc[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lv;
		logic                  lvld;
		logic [DATA_WIDTH-1:0] rv;
		logic                  rvld;

		if (i == 0) begin : g_first
			assign lv   = '0;
			assign lvld = 1'b0;
		end else begin : g_mid_l
			assign lv   = val[i-1];
			assign lvld = vld[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rv   = '0;
			assign rvld = 1'b0;
		end else begin : g_mid_r
			assign rv   = val[i+1];
			assign rvld = vld[i+1];
		end

		olt_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key      (key),
			.left_val (lv),
			.left_vld (lvld),
			.right_val(rv),
			.right_vld(rvld),
			.hit_in   (hit[i]),
			.hit_out  (hit[i+1]),
			.acc_in   (acc[i]),
			.acc_out  (acc[i+1]),
			.val      (val[i]),
			.vld      (vld[i])
		);
	end

	// Result and count
	always_comb begin
		fill_nxt = fill_q;
		if (is_ins) begin
			ok_c = !full;
			if (!full) fill_nxt = fill_q + CW'(1);
		end else if (is_rem) begin
			ok_c = hit[DEPTH];
			if (hit[DEPTH]) fill_nxt = fill_q - CW'(1);
		end else if (cmd == CMD_SEARCH) begin
			ok_c = hit[DEPTH];
		end else begin
			ok_c = 1'b0;
		end
	end

	assign cnt_ext = 64'(fill_nxt);
	assign rem_ext = 64'(is_rem ? acc[DEPTH] : '0);

	// Fill count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) fill_q <= fill_nxt;
			if (accept) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q  <= ok_c;
			rem_q <= rem_ext[REM_W-1:0];
			cnt_q <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, cnt_q, rem_q, ok_q};

	// Checks
	logic [DEPTH:0] exp_vld;
	assign exp_vld = ~({(DEPTH + 1){1'b1}} << fill_q);

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_vld_packed: assert property (@(posedge clk) disable iff (!arst_n)
		vld == exp_vld[DEPTH-1:0])
		else $error("valid bits not packed at the front or not matching fill");

	a_full_ins: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_ins && full |=> fill_q == CW'(DEPTH) && !ok_q)
		else $error("insert into full list changed state");

	a_one_hit_per_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rem && hit[DEPTH] |=> fill_q == $past(fill_q) - CW'(1))
		else $error("remove did not drop exactly one entry");

	a_result_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted request produced no result");

endmodule

// ----- tb/list_table_checker.sv -----
`timescale 1ns / 1ps

// Watches the request and result channels of the ordered list table and keeps its own copy of
// the list. Every accepted request is applied to that copy; every accepted result is
// matched against the oldest outstanding prediction.
module list_table_checker #(
	parameter int DEPTH = olt_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // item_value[31:0]
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // ok[0], removed_value[32:1], entry_count[37:33]
	output int          fail_count,
	output int          pending,
	output int          request_count,
	output int          result_count,
	output int          full_rejects,
	output int          empty_rejects
);
	import olt_pkg::*;

	typedef struct packed {
		logic        ok;
		logic [31:0] removed_value;
		logic [4:0]  entry_count;
	} list_result_t;

	// Shadow copy of the table
	logic [31:0]  shadow_entries [DEPTH];
	int           shadow_fill;
	list_result_t expected_results [$];

	initial begin
		fail_count    = 0;
		pending       = 0;
		request_count = 0;
		result_count  = 0;
		full_rejects  = 0;
		empty_rejects = 0;
		shadow_fill   = 0;
	end

	// Removes the entry at pos and closes the gap behind it
	task automatic take_entry(input int pos, inout list_result_t res);
		res.removed_value = shadow_entries[pos];
		res.ok = 1'b1;
		for (int i = pos; i < shadow_fill - 1; i++)
			shadow_entries[i] = shadow_entries[i + 1];
		shadow_fill--;
	endtask

	// Applies one request to the shadow list and returns the result it should give
	task automatic apply_list_request(input logic [2:0] code, input logic [31:0] key,
			output list_result_t res);
		int pos;
		res = '0;
		pos = 0;
		case (code)
			CMD_INS_ORD, CMD_INS_FRONT, CMD_INS_REAR: begin
				// first entry >= key, searched from the front even if unsorted
				if (code == CMD_INS_ORD) begin
					while (pos < shadow_fill && shadow_entries[pos] < key)
						pos++;
				end else if (code == CMD_INS_REAR) begin
					pos = shadow_fill;
				end
				if (shadow_fill < DEPTH) begin
					for (int i = shadow_fill; i > pos; i--)
						shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[pos] = key;
					shadow_fill++;
					res.ok = 1'b1;
				end else begin
					full_rejects++;
				end
			end
			CMD_SEARCH: begin
				while (pos < shadow_fill && shadow_entries[pos] != key)
					pos++;
				res.ok = (pos < shadow_fill);
			end
			CMD_REM_FRONT, CMD_REM_REAR: begin
				if (shadow_fill == 0)
					empty_rejects++;
				else
					take_entry((code == CMD_REM_FRONT) ? 0 : shadow_fill - 1, res);
			end
			CMD_REM_VAL: begin
				if (shadow_fill == 0)
					empty_rejects++;
				while (pos < shadow_fill && shadow_entries[pos] != key)
					pos++;
				if (pos < shadow_fill)
					take_entry(pos, res);
			end
			default: ;
		endcase
		res.entry_count = 5'(shadow_fill);
	endtask

	// Results first: a request accepted at this edge answers at a later one
	always @(posedge clk) begin : watch
		list_result_t want;
		list_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.ok            = m_tdata[0];
				got.removed_value = m_tdata[32:1];
				got.entry_count   = m_tdata[37:33];
				result_count++;
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						fail_count++;
					end
					if (got.removed_value !== want.removed_value) begin
						$error("removed_value: expected %h, got %h",
							want.removed_value, got.removed_value);
						fail_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, got.entry_count);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_list_request(s_tuser, s_tdata, want);
				expected_results.push_back(want);
				request_count++;
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import olt_pkg::*;

	localparam logic [2:0] CMD_UNUSED     = 3'd7;
	localparam int         RANDOM_REQS    = 1850;
	localparam int         TIMEOUT_CYCLES = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	int fail_count;
	int pending;
	int request_count;
	int result_count;
	int full_rejects;
	int empty_rejects;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;

	// Values recently stored, so searches and removes often hit
	logic [31:0] recent_keys [8];

	ordered_list_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	list_table_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.request_count (request_count),
		.result_count  (result_count),
		.full_rejects  (full_rejects),
		.empty_rejects (empty_rejects)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Receiver stalls at random
	initial m_tready = 1'b0;
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Offers one request, with random idle cycles ahead of it; returns at a falling edge
	task automatic send_request(input logic [2:0] code, input logic [31:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= code;
		s_tdata  <= key;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(15);
			2: return recent_keys[$urandom_range(7)];
			default: return 32'hFFFF_FFFF - $urandom_range(3);
		endcase
	endfunction

	initial begin : stimulus
		logic [2:0]  code;
		logic [31:0] key;
		logic        filling;
		logic        want_insert;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		arst_n        = 1'b0;
		send_idle_pct = 9;
		recv_idle_pct = 45;
		filling       = 1'b1;
		foreach (recent_keys[i])
			recent_keys[i] = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty list: every remove and the search fail; unused code does nothing
		send_request(CMD_SEARCH, 32'd0);
		send_request(CMD_REM_FRONT, 32'd0);
		send_request(CMD_REM_REAR, 32'd0);
		send_request(CMD_REM_VAL, 32'd0);
		send_request(CMD_UNUSED, 32'hFFFF_FFFF);
		// Rear removal from a one-entry list
		send_request(CMD_INS_REAR, 32'h1234_5678);
		send_request(CMD_REM_REAR, 32'd0);
		// Ordered inserts at the value extremes and a duplicate
		send_request(CMD_INS_ORD, 32'hFFFF_FFFF);
		send_request(CMD_INS_ORD, 32'd0);
		send_request(CMD_INS_ORD, 32'd5);
		send_request(CMD_INS_ORD, 32'd5);
		// Break the ordering, then insert in order into the unsorted list
		send_request(CMD_INS_FRONT, 32'd9);
		send_request(CMD_INS_REAR, 32'd2);
		send_request(CMD_INS_ORD, 32'd7);
		send_request(CMD_SEARCH, 32'd5);
		send_request(CMD_SEARCH, 32'd4);
		send_request(CMD_SEARCH, 32'hFFFF_FFFF);
		// Duplicate value: only the one nearest the front goes
		send_request(CMD_REM_VAL, 32'd5);
		send_request(CMD_REM_VAL, 32'd99);
		send_request(CMD_REM_FRONT, 32'd0);
		send_request(CMD_REM_REAR, 32'd0);
		send_request(CMD_UNUSED, 32'd0);

		// Random part: alternate fill-heavy and drain-heavy stretches
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n == RANDOM_REQS / 3) begin
				send_idle_pct = 45;
				recv_idle_pct = 9;
			end
			if (n == 2 * RANDOM_REQS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (n % 40 == 0)
				filling = ~filling;

			want_insert = filling ? ($urandom_range(99) < 80) : ($urandom_range(99) < 20);
			if ($urandom_range(99) < 2) begin
				code = CMD_UNUSED;
				key  = $urandom;
			end else if ($urandom_range(99) < 10) begin
				code = CMD_SEARCH;
				key  = ($urandom_range(9) < 7) ? recent_keys[$urandom_range(7)] : pick_key();
			end else if (want_insert) begin
				case ($urandom_range(3))
					0, 1: code = CMD_INS_ORD;
					2:    code = CMD_INS_FRONT;
					default: code = CMD_INS_REAR;
				endcase
				key = pick_key();
				recent_keys[$urandom_range(7)] = key;
			end else begin
				case ($urandom_range(3))
					0: code = CMD_REM_FRONT;
					1: code = CMD_REM_REAR;
					default: code = CMD_REM_VAL;
				endcase
				key = ($urandom_range(9) < 7) ? recent_keys[$urandom_range(7)] : pick_key();
			end
			send_request(code, key);
		end
		s_tvalid <= 1'b0;

		// Drain, then allow a few cycles for anything stray
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("covered %0d requests and %0d results over three idle mixes",
			request_count, result_count);
		$display("inserts refused on a full list: %0d, removes on an empty list: %0d",
			full_rejects, empty_rejects);
		if (fail_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
